// ===== sv/itrd_pkg.sv =====
// Shared types and constants for the radix digit writer.
// No dependencies; every other file imports this package.
package itrd_pkg;

  // Alphabet storage: sixteen byte slots in two 64-bit registers
  localparam int SYM_SLOTS = 16;
  localparam int SLOT_W    = 4;
  localparam int SYM_W     = 8;
  localparam int CNT_W     = 5;

  // Configuration port geometry: 64-bit registers at byte address 8*i
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  localparam logic [CNT_W-1:0] COUNT_RESET = 5'd10;

  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;

  // Register index taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_SYMBOLS_LOW  = 2'd0,
    REG_SYMBOLS_HIGH = 2'd1,
    REG_SYMBOL_COUNT = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_SIGN,
    ST_READ,
    ST_LOAD,
    ST_EMIT
  } state_t;

  // Sequencer commands to the bit-serial divider
  typedef struct packed {
    logic load;
    logic restart;
    logic step;
  } div_ctrl_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic done;
    logic nonzero;
  } div_stat_t;

endpackage

// ===== sv/integer_to_radix_digits_top.sv =====
// Top level of the radix digit writer: stream ports, sequencer, digit
// buffer. Depends on itrd_pkg, itrd_cfg and itrd_div.
//
//   channel  | signals                                   | carries
//   ---------+-------------------------------------------+---------------------------
//   input    | s_tvalid s_tready s_tdata                 | value
//   output   | m_tvalid m_tready m_tdata m_tlast m_tuser | character, last, status
//   config   | psel penable pwrite paddr pwdata prdata   | symbols_low/high, count
//
// Each digit takes a full pass of the bit-serial divider; each digit character
// then goes through buffer read, lookup and present, the sign through its own
// load and present, and every value first through accept and the alphabet check.
// Reset is synchronous and clears the sequencer and configuration registers.
// One value is worked on at a time; a stalled output holds the sequencer.
module integer_to_radix_digits_top
  import itrd_pkg::*;
#(
  parameter int MAX_SYMBOLS = 16,
  parameter int VALUE_BITS  = 32,
  localparam int IN_W = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // [VALUE_BITS-1:0] value
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [7:0] character
  output logic              m_tlast,
  output logic              m_tuser,   // [0] status
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int DIGIT_W = $clog2(MAX_SYMBOLS);
  localparam int REM_W   = DIGIT_W + 1;
  localparam int AW      = $clog2(VALUE_BITS);
  localparam int NDW     = $clog2(VALUE_BITS + 1);

  state_t                state;
  state_t                state_next;
  logic [VALUE_BITS-1:0] val_q;
  logic [VALUE_BITS-1:0] mag_init;
  logic                  neg;
  logic [NDW-1:0]        nd;
  logic [NDW-1:0]        nd_dec;
  logic                  mem_we;
  logic [DIGIT_W-1:0]    digit_mem [VALUE_BITS];
  logic [DIGIT_W-1:0]    rd_data;
  logic [SYM_W-1:0]      symbol;
  logic [REM_W-1:0]      radix;
  logic [REM_W-1:0]      div_rem;
  logic                  alphabet_ok;
  div_ctrl_t             div_ctrl;
  div_stat_t             div_stat;

  assign pready = 1'b1;

  itrd_cfg #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .digit      (rd_data),
    .symbol     (symbol),
    .radix      (radix),
    .alphabet_ok(alphabet_ok)
  );

  itrd_div #(
    .VALUE_BITS(VALUE_BITS),
    .REM_W     (REM_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .load_value(mag_init),
    .radix     (radix),
    .rem       (div_rem),
    .stat      (div_stat)
  );

  // Magnitude of the latched value; the most negative value maps onto itself
  assign mag_init = val_q[VALUE_BITS-1] ? (~val_q + 1'b1) : val_q;
  assign nd_dec   = nd - 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_CHECK;
      ST_CHECK:  state_next = alphabet_ok ? ST_DIVIDE : ST_EMIT;
      ST_DIVIDE: begin
        if (div_stat.done && !div_stat.nonzero) begin
          state_next = neg ? ST_SIGN : ST_READ;
        end
      end
      ST_SIGN:   state_next = ST_EMIT;
      ST_READ:   state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_EMIT;
      ST_EMIT: begin
        if (m_tready) state_next = m_tlast ? ST_IDLE : ST_READ;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    mem_we   = 1'b0;
    div_ctrl = '0;
    case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_CHECK: div_ctrl.load = alphabet_ok;
      ST_DIVIDE: begin
        if (div_stat.done) begin
          mem_we           = 1'b1;
          div_ctrl.restart = div_stat.nonzero;
        end else begin
          div_ctrl.step = 1'b1;
        end
      end
      ST_EMIT:  m_tvalid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Digit count: grow while dividing, shrink while reading back
  always_ff @(posedge clk) begin
    if (rst) begin
      nd <= '0;
    end else begin
      case (state)
        ST_CHECK:  nd <= '0;
        ST_DIVIDE: if (div_stat.done) nd <= nd + 1'b1;
        ST_READ:   nd <= nd_dec;
        default: ;
      endcase
    end
  end

  // Latch the input transaction and its sign
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      val_q <= s_tdata[VALUE_BITS-1:0];
    end
    if (state == ST_CHECK) begin
      neg <= val_q[VALUE_BITS-1];
    end
  end

  // Digit buffer, least significant digit at address 0
  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[nd[AW-1:0]] <= div_rem[DIGIT_W-1:0];
    end
    rd_data <= digit_mem[nd_dec[AW-1:0]];
  end

  // Output register
  always_ff @(posedge clk) begin
    case (state)
      ST_CHECK: begin
        if (!alphabet_ok) begin
          m_tdata <= '0;
          m_tlast <= 1'b1;
          m_tuser <= 1'b1;
        end
      end
      ST_SIGN: begin
        m_tdata <= CH_MINUS;
        m_tlast <= 1'b0;
        m_tuser <= 1'b0;
      end
      ST_LOAD: begin
        m_tdata <= symbol;
        m_tlast <= (nd == '0);
        m_tuser <= 1'b0;
      end
      default: ;
    endcase
  end

  // Invalid-alphabet results are a lone zero character
  a_invalid_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0 && m_tlast)
    else $error("invalid status without zero character and last");

  // Input and output never both active
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a result is shown");

  // Digit count bounded by the value width
  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    nd <= NDW'(VALUE_BITS))
    else $error("digit buffer overrun");

  // An accepted transaction always goes to the alphabet check
  a_accept_check: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_CHECK)
    else $error("accepted value skipped the alphabet check");

endmodule

// ===== sv/itrd_cfg.sv =====
// Configuration registers with APB-style access, alphabet validity check
// and digit-to-symbol lookup. Depends on itrd_pkg.
module itrd_cfg
  import itrd_pkg::*;
#(
  parameter int MAX_SYMBOLS = 16,
  localparam int DIGIT_W = $clog2(MAX_SYMBOLS),
  localparam int REM_W   = DIGIT_W + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  input  logic [DIGIT_W-1:0] digit,
  output logic [SYM_W-1:0]   symbol,
  output logic [REM_W-1:0]   radix,
  output logic               alphabet_ok
);

  logic [DATA_W-1:0] symbols_low;
  logic [DATA_W-1:0] symbols_high;
  logic [CNT_W-1:0]  symbol_count;
  logic [SYM_SLOTS-1:0][SYM_W-1:0] syms;
  logic              wr_en;
  logic [1:0]        reg_idx;
  logic              bad;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:3];
  assign syms    = {symbols_high, symbols_low};

  // Register writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      symbols_low  <= '0;
      symbols_high <= '0;
      symbol_count <= COUNT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SYMBOLS_LOW:  symbols_low  <= pwdata;
        REG_SYMBOLS_HIGH: symbols_high <= pwdata;
        REG_SYMBOL_COUNT: symbol_count <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      REG_SYMBOLS_LOW:  prdata = symbols_low;
      REG_SYMBOLS_HIGH: prdata = symbols_high;
      REG_SYMBOL_COUNT: prdata = {{(DATA_W-CNT_W){1'b0}}, symbol_count};
      default:          prdata = '0;
    endcase
  end

  // Flag a short or oversized alphabet, a sign symbol, or a repeated symbol
  always_comb begin
    bad = (symbol_count < CNT_W'(2)) || (symbol_count > CNT_W'(MAX_SYMBOLS));
    for (int i = 0; i < SYM_SLOTS; i++) begin
      if (CNT_W'(i) < symbol_count) begin
        if (syms[i] == CH_PLUS || syms[i] == CH_MINUS) begin
          bad = 1'b1;
        end
        for (int j = 0; j < i; j++) begin
          if (syms[j] == syms[i]) begin
            bad = 1'b1;
          end
        end
      end
    end
  end

  // Hold the check result in a register to keep it off the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_ok <= 1'b0;
    end else begin
      alphabet_ok <= !bad;
    end
  end

  assign radix  = symbol_count[REM_W-1:0];
  assign symbol = syms[SLOT_W'(digit)];

endmodule

// ===== sv/itrd_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle while step is
// asserted, quotient kept in place of the dividend, remainder ready after
// VALUE_BITS steps. Depends on itrd_pkg.
module itrd_div
  import itrd_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int REM_W      = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  div_ctrl_t             ctrl,
  input  logic [VALUE_BITS-1:0] load_value,
  input  logic [REM_W-1:0]      radix,
  output logic [REM_W-1:0]      rem,
  output div_stat_t             stat
);

  localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] mag;
  logic [CNT_BITS-1:0]   cnt;
  logic                  nz;
  logic [REM_W:0]        r2;
  logic [REM_W:0]        r2_sub;
  logic                  ge;
  logic [REM_W-1:0]      rem_next;

  // Shift in the next dividend bit and try one subtract
  always_comb begin
    r2       = {rem, mag[VALUE_BITS-1]};
    ge       = r2 >= {1'b0, radix};
    r2_sub   = r2 - {1'b0, radix};
    rem_next = ge ? r2_sub[REM_W-1:0] : r2[REM_W-1:0];
  end

  // Step counter and nonzero-quotient flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      nz  <= 1'b0;
    end else if (ctrl.load || ctrl.restart) begin
      cnt <= '0;
      nz  <= 1'b0;
    end else if (ctrl.step) begin
      cnt <= cnt + 1'b1;
      nz  <= nz | ge;
    end
  end

  // Dividend/quotient shift register and partial remainder
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag <= load_value;
      rem <= '0;
    end else if (ctrl.restart) begin
      rem <= '0;
    end else if (ctrl.step) begin
      mag <= {mag[VALUE_BITS-2:0], ge};
      rem <= rem_next;
    end
  end

  assign stat.done    = (cnt == CNT_BITS'(VALUE_BITS));
  assign stat.nonzero = nz;

endmodule

// ===== test/tb_integer_to_radix_digits_top.sv =====
// Self-checking testbench for integer_to_radix_digits_top: directed table, then random
// alphabets and values, checked against an in-bench digit predictor.
// Depends on itrd_pkg and the RTL under sv/.
`timescale 1ns / 1ps

module tb_integer_to_radix_digits_top
  import itrd_pkg::*;
();

  localparam int STALL_LIMIT  = 10000;
  localparam int HOLD_CYCLES  = 2000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 21;
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  localparam logic [63:0] HEX_LO = 64'h3736_3534_3332_3130;
  localparam logic [63:0] HEX_HI = 64'h4645_4443_4241_3938;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       status;
  } text_char_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  count;
  } alphabet_t;

  typedef struct packed {
    logic [3:0]  alpha;
    logic [31:0] value;
    logic        typed;
    logic [7:0]  exp_char;
    logic        exp_invalid;
  } directed_row_t;

  typedef enum int {FLAW_PLUS, FLAW_MINUS, FLAW_REPEAT, FLAW_COUNT, FLAW_NONE} flaw_t;

  // Alphabet 0 is the reset state and is never written
  localparam int ALPHA_RESET = 0;
  alphabet_t directed_alpha [12] = '{
    '{64'h0, 64'h0, COUNT_RESET},                    // ten zero bytes: repeated symbol
    '{HEX_LO, 64'h2D2D_2D2D_2D2D_3938, 5'd10},       // decimal, '-' in unused slots
    '{HEX_LO, HEX_HI, 5'd16},                        // hex, widest radix
    '{64'h2B2B_2B2B_2B2B_0100, 64'h2D2D_2D2D_2D2D_2D2D, 5'd2}, // binary with a zero byte
    '{64'h0000_0000_00FF_7A00, 64'h0, 5'd3},         // radix 3, symbol 0xFF
    '{64'h3736_2B34_3332_3130, 64'h0000_0000_0000_3938, 5'd10}, // '+' in use
    '{HEX_LO, 64'h2D45_4443_4241_3938, 5'd16},       // '-' in the top slot
    '{HEX_LO, 64'h3045_4443_4241_3938, 5'd16},       // first and last symbol equal
    '{HEX_LO, HEX_HI, 5'd1},                         // count too small
    '{HEX_LO, HEX_HI, 5'd17},                        // count too large
    '{HEX_LO, HEX_HI, 5'd0},
    '{HEX_LO, HEX_HI, 5'd31}
  };

  directed_row_t directed_rows [23] = '{
    '{4'd0,  32'h0000_0000, 1'b1, 8'h00, 1'b1},
    '{4'd0,  32'h8000_0000, 1'b1, 8'h00, 1'b1},
    '{4'd1,  32'h0000_0000, 1'b1, 8'h30, 1'b0},
    '{4'd1,  32'h0000_0009, 1'b1, 8'h39, 1'b0},
    '{4'd1,  32'h7FFF_FFFF, 1'b0, 8'h00, 1'b0},
    '{4'd1,  32'h8000_0000, 1'b0, 8'h00, 1'b0},
    '{4'd1,  32'hFFFF_FFFF, 1'b0, 8'h00, 1'b0},
    '{4'd2,  32'h7FFF_FFFF, 1'b0, 8'h00, 1'b0},
    '{4'd2,  32'h8000_0000, 1'b0, 8'h00, 1'b0},
    '{4'd2,  32'h0000_00FF, 1'b0, 8'h00, 1'b0},
    '{4'd2,  32'hFFFF_FFF1, 1'b0, 8'h00, 1'b0},
    '{4'd3,  32'h8000_0000, 1'b0, 8'h00, 1'b0},
    '{4'd3,  32'h7FFF_FFFF, 1'b0, 8'h00, 1'b0},
    '{4'd3,  32'h0000_0000, 1'b1, 8'h00, 1'b0},
    '{4'd4,  32'hFFFF_FFFF, 1'b0, 8'h00, 1'b0},
    '{4'd4,  32'h0000_0005, 1'b0, 8'h00, 1'b0},
    '{4'd5,  32'h1234_5678, 1'b1, 8'h00, 1'b1},
    '{4'd6,  32'hFFFF_FFFF, 1'b1, 8'h00, 1'b1},
    '{4'd7,  32'h0000_0000, 1'b1, 8'h00, 1'b1},
    '{4'd8,  32'h0000_0001, 1'b1, 8'h00, 1'b1},
    '{4'd9,  32'h8000_0000, 1'b1, 8'h00, 1'b1},
    '{4'd10, 32'h7FFF_FFFF, 1'b1, 8'h00, 1'b1},
    '{4'd11, 32'hDEAD_BEEF, 1'b1, 8'h00, 1'b1}
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [31:0]       s_tdata;   // [31:0] value
  logic              m_tvalid;
  logic              m_tready;
  logic [7:0]        m_tdata;   // [7:0] character
  logic              m_tlast;
  logic              m_tuser;   // [0] status
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Register copy used for prediction
  logic [63:0] alpha_lo    = 64'h0;
  logic [63:0] alpha_hi    = 64'h0;
  logic [4:0]  alpha_count = COUNT_RESET;

  text_char_t expected_text[$];
  int         errors = 0;
  int         idle_cycles = 0;
  int         burst_left = 1;
  bit         hold_request = 1'b0;

  integer_to_radix_digits_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] symbol_of(input int unsigned slot);
    return (slot < 8) ? alpha_lo[slot*8 +: 8] : alpha_hi[(slot-8)*8 +: 8];
  endfunction

  function automatic bit alphabet_valid();
    int n;
    logic [7:0] s;
    n = alpha_count;
    if (n < 2 || n > SYM_SLOTS) return 1'b0;
    for (int i = 0; i < n; i++) begin
      s = symbol_of(i);
      if (s == CH_PLUS || s == CH_MINUS) return 1'b0;
      for (int j = 0; j < i; j++)
        if (symbol_of(j) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Queue the characters one value should produce, sign first, then digits high to low
  function automatic void predict_text(input logic [31:0] v);
    logic [31:0] mag;
    logic [31:0] radix;
    logic [3:0]  digits[$];
    text_char_t  c;
    if (!alphabet_valid()) begin
      expected_text.push_back('{character: 8'h00, last: 1'b1, status: 1'b1});
      return;
    end
    radix = 32'(alpha_count);
    mag = v[31] ? -v : v;
    do begin
      digits.push_front(4'(mag % radix));
      mag = mag / radix;
    end while (mag != 0);
    if (v[31]) expected_text.push_back('{character: CH_MINUS, last: 1'b0, status: 1'b0});
    foreach (digits[i]) begin
      c.character = symbol_of(digits[i]);
      c.last      = (i == digits.size() - 1);
      c.status    = 1'b0;
      expected_text.push_back(c);
    end
  endfunction

  // Two-phase register write; the bus is left idle before the task returns
  task automatic reg_write(input logic [1:0] idx, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SYMBOLS_LOW:  alpha_lo = data;
      REG_SYMBOLS_HIGH: alpha_hi = data;
      REG_SYMBOL_COUNT: alpha_count = data[4:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Stop offering, wait for every expected character, then let the block settle
  task automatic drain_text();
    s_tvalid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic load_alphabet(input alphabet_t a);
    drain_text();
    reg_write(REG_SYMBOLS_LOW, a.lo);
    reg_write(REG_SYMBOLS_HIGH, a.hi);
    reg_write(REG_SYMBOL_COUNT, 64'(a.count));
    // out-of-range index must leave every register untouched
    reg_write(REG_UNMAPPED, {DATA_W{1'b1}});
  endtask

  // Offer one value; bursts of back-to-back transactions with random gaps
  task automatic offer_value(input logic [31:0] v, input bit typed, input text_char_t typed_char);
    int gap;
    if (typed) expected_text.push_back(typed_char);
    else predict_text(v);
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(0, 31);
      2: v = -($urandom >> $urandom_range(0, 31));
      3: begin
        v = $urandom_range(0, 40);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32'h0000_0000;
          1: v = 32'h0000_0001;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
    endcase
    return v;
  endfunction

  // Distinct usable symbols in the active slots, anything in the rest; sometimes spoiled
  task automatic random_alphabet(output alphabet_t a);
    logic [7:0] syms[16];
    bit         taken[256];
    int         n;
    int         slot;
    int         pick;
    logic [7:0] b;
    flaw_t      flaw;
    n = $urandom_range(2, 16);
    foreach (taken[k]) taken[k] = 1'b0;
    for (slot = 0; slot < 16; slot++) begin
      if (slot < n) begin
        do b = 8'($urandom); while (taken[b] || b == CH_PLUS || b == CH_MINUS);
        taken[b] = 1'b1;
        syms[slot] = b;
      end else begin
        syms[slot] = 8'($urandom);
      end
    end
    pick = $urandom_range(0, 9);
    flaw = (pick < 4) ? flaw_t'(pick) : FLAW_NONE;
    case (flaw)
      FLAW_PLUS:  syms[$urandom_range(0, n - 1)] = CH_PLUS;
      FLAW_MINUS: syms[$urandom_range(0, n - 1)] = CH_MINUS;
      FLAW_REPEAT: begin
        slot = $urandom_range(1, n - 1);
        syms[slot] = syms[$urandom_range(0, slot - 1)];
      end
      FLAW_COUNT: n = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
      default: ;
    endcase
    for (slot = 0; slot < 8; slot++) begin
      a.lo[slot*8 +: 8] = syms[slot];
      a.hi[slot*8 +: 8] = syms[slot + 8];
    end
    a.count = 5'(n);
  endtask

  // Stimulus: directed table, then random phases
  initial begin
    int         cur_alpha;
    alphabet_t  a;
    text_char_t typed_char;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cur_alpha = ALPHA_RESET;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].alpha != cur_alpha) begin
        cur_alpha = directed_rows[i].alpha;
        load_alphabet(directed_alpha[cur_alpha]);
      end
      typed_char.character = directed_rows[i].exp_invalid ? 8'h00 : directed_rows[i].exp_char;
      typed_char.last      = 1'b1;
      typed_char.status    = directed_rows[i].exp_invalid;
      offer_value(directed_rows[i].value, directed_rows[i].typed, typed_char);
    end

    for (int p = 0; p < PHASES; p++) begin
      random_alphabet(a);
      load_alphabet(a);
      if (p == 2) hold_request = 1'b1;
      repeat (PHASE_ITEMS) offer_value(random_value(), 1'b0, '0);
    end

    drain_text();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Receiver: randomly chosen stall patterns; one long hold-off on request
  initial begin
    int  mode;
    int  tick;
    bit  hold_served;
    mode        = 0;
    tick        = 0;
    hold_served = 1'b0;
    m_tready    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (tick % 64 == 0) mode = $urandom_range(0, 3);
      tick++;
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 1);
        2: m_tready <= ($urandom_range(0, 7) != 0);
        default: m_tready <= (tick % 5 != 0);
      endcase
    end
  end

  // Compare each output transaction with the oldest expected character
  always @(posedge clk) begin
    text_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_text.size() == 0) begin
        $error("unexpected character %0h (last %0d, status %0d)", m_tdata, m_tlast, m_tuser);
        errors++;
      end else begin
        want = expected_text.pop_front();
        if (m_tdata !== want.character) begin
          $error("character: expected %0h, got %0h", want.character, m_tdata);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_tlast);
          errors++;
        end
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
sv/itrd_pkg.sv
sv/itrd_cfg.sv
sv/itrd_div.sv
sv/integer_to_radix_digits_top.sv
test/tb_integer_to_radix_digits_top.sv
